// ===== hdl/pru_pkg.sv =====
// Shared types and constants of the polar ring unwrapper.
package pru_pkg;

    // Default sizes of the source image store and the sine table
    localparam int DEF_MAX_IMAGE_WIDTH  = 512;
    localparam int DEF_MAX_IMAGE_HEIGHT = 512;
    localparam int DEF_ANGLE_STEPS      = 4096;

    // Configuration register indexes
    localparam logic [2:0] REG_CENTER_X     = 3'd0;
    localparam logic [2:0] REG_CENTER_Y     = 3'd1;
    localparam logic [2:0] REG_RADIUS_INNER = 3'd2;
    localparam logic [2:0] REG_RADIUS_OUTER = 3'd3;
    localparam logic [2:0] REG_RING_ROWS    = 3'd4;
    localparam logic [2:0] REG_RING_COLS    = 3'd5;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd6;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd7;

    // Item kinds on s_tuser
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Fixed point constants
    localparam int          Q23_SHIFT   = 23;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RDIV,
        S_RDIV_WAIT,
        S_KDIV,
        S_KDIV_WAIT,
        S_ROM_S,
        S_ROM_C,
        S_MUL,
        S_SUM,
        S_CHK,
        S_OUT
    } pru_state_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hdl/pru_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module pru_divider #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    output logic [NUM_W-1:0]     quo,
    output pru_pkg::div_stat_t   stat
);
    import pru_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    // One shift and trial subtract per cycle
    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, num_reg[NUM_W-1]};
        fits      = (rem_sh >= {1'b0, den_reg});
        if (start) begin
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            num_next = {num_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo       = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hdl/pru_sine_rom.sv =====
// Q1.15 sine table built at elaboration, registered read.
module pru_sine_rom #(
    parameter int ANGLE_STEPS = 4096,
    parameter int AB          = 12
) (
    input  logic                aclk,
    input  logic [AB-1:0]       addr,
    output logic signed [15:0]  q
);
    import pru_pkg::*;

    // Taylor series to x^15 on a folded Q30 angle, rounded to Q15
    function automatic logic signed [15:0] sine_q15(input logic [63:0] a_in);
        logic [63:0]        a;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        logic               neg;
        a   = a_in;
        neg = 1'b0;
        if (a >= PI_Q30) begin
            a   = a - PI_Q30;
            neg = 1'b1;
        end
        if (a > HALF_PI_Q30) begin
            a = PI_Q30 - a;
        end
        x2   = (a * a) >> 30;
        term = a;
        sum  = $signed(a);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        rnd = ($unsigned(sum) + 64'd16384) >> 15;
        if (rnd > 64'd32767) begin
            rnd = 64'd32767;
        end
        return neg ? -$signed(16'(rnd)) : $signed(16'(rnd));
    endfunction

    logic signed [15:0] sin_tab [ANGLE_STEPS];

    // One constant per table entry
    for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_tab
        localparam logic [63:0] ANG = (64'(i) * TWO_PI_Q30) / 64'(ANGLE_STEPS);
        assign sin_tab[i] = sine_q15(ANG);
    end

    always_ff @(posedge aclk) begin
        q <= sin_tab[addr];
    end

endmodule

// ===== hdl/pru_image_mem.sv =====
// Source image store: one write port, one registered read port.
module pru_image_mem #(
    parameter int AW = 18
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    logic [7:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/polar_ring_unwrap.sv =====
// Top level of the polar ring unwrapper: config, sequencer and position math.
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    s_tdata fields, s_tuser = op
//  m_*       out  m_tvalid / m_tready    m_tdata = sample_value, m_tuser = outside
//  cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A write item is taken in S_IDLE and goes straight to the image store. A sample
// item passes through S_RDIV, S_KDIV and their waits on the bit-serial divider,
// then S_ROM_S, S_ROM_C, S_MUL, S_SUM, S_CHK and S_OUT before m_tvalid rises;
// the next item is taken only once the sequencer is back in S_IDLE.
// Reset clears control state only; the image store holds nothing until written.
// A finished result waits in the output register; the next item is taken
// meanwhile, and a later sample holds in S_OUT until that register frees.
// ANGLE_STEPS and the image sizes must be powers of two.
module polar_ring_unwrap #(
    parameter int MAX_IMAGE_WIDTH  = pru_pkg::DEF_MAX_IMAGE_WIDTH,
    parameter int MAX_IMAGE_HEIGHT = pru_pkg::DEF_MAX_IMAGE_HEIGHT,
    parameter int ANGLE_STEPS      = pru_pkg::DEF_ANGLE_STEPS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_col[8:0], pixel_row[17:9], pixel_value[25:18], ring_col[35:26],
    // ring_row[43:36], zero fill[47:44]
    input  logic [47:0] s_tdata,
    // op[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // sample_value[7:0]
    output logic [7:0]  m_tdata,
    // outside_image[0]
    output logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import pru_pkg::*;

    localparam int AB        = $clog2(ANGLE_STEPS);
    localparam int XW        = $clog2(MAX_IMAGE_WIDTH);
    localparam int YW        = $clog2(MAX_IMAGE_HEIGHT);
    localparam int AW        = $clog2(MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT);
    localparam int WW        = $clog2(MAX_IMAGE_WIDTH + 1);
    localparam int HW        = $clog2(MAX_IMAGE_HEIGHT + 1);
    localparam int DIV_NUM_W = (10 + AB > 26) ? 10 + AB : 26;
    localparam int DEN_W     = 11;
    localparam int RQ_W      = 28;
    localparam int PR_W      = RQ_W + 16;
    localparam int SUM_W     = PR_W + 2;
    localparam int POS_W     = SUM_W - Q23_SHIFT;
    localparam int QTR       = ANGLE_STEPS / 4;

    // Configuration registers
    logic signed [10:0] center_x_reg, center_y_reg;
    logic [9:0]         radius_inner_reg, radius_outer_reg;
    logic [8:0]         ring_rows_reg;
    logic [10:0]        ring_cols_reg;
    logic [9:0]         image_width_reg, image_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg     <= 11'sd256;
            center_y_reg     <= 11'sd256;
            radius_inner_reg <= 10'd32;
            radius_outer_reg <= 10'd128;
            ring_rows_reg    <= 9'd64;
            ring_cols_reg    <= 11'd512;
            image_width_reg  <= 10'd512;
            image_height_reg <= 10'd512;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CENTER_X:     center_x_reg     <= $signed(cfg_data);
                REG_CENTER_Y:     center_y_reg     <= $signed(cfg_data);
                REG_RADIUS_INNER: radius_inner_reg <= cfg_data[9:0];
                REG_RADIUS_OUTER: radius_outer_reg <= cfg_data[9:0];
                REG_RING_ROWS:    ring_rows_reg    <= cfg_data[8:0];
                REG_RING_COLS:    ring_cols_reg    <= cfg_data;
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[9:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Input field views
    logic [8:0] in_pixel_col, in_pixel_row;
    logic [7:0] in_pixel_value, in_ring_row;
    logic [9:0] in_ring_col;
    assign in_pixel_col   = s_tdata[8:0];
    assign in_pixel_row   = s_tdata[17:9];
    assign in_pixel_value = s_tdata[25:18];
    assign in_ring_col    = s_tdata[35:26];
    assign in_ring_row    = s_tdata[43:36];

    // Derived per-configuration values
    logic signed [10:0] delta;
    logic [9:0]         delta_abs;
    logic               delta_neg;
    logic [DEN_W-1:0]   den_r, den_c;
    logic [WW-1:0]      lim_w;
    logic [HW-1:0]      lim_h;

    always_comb begin
        delta     = $signed({1'b0, radius_outer_reg}) - $signed({1'b0, radius_inner_reg});
        delta_neg = delta[10];
        delta_abs = delta_neg ? 10'(-delta) : delta[9:0];
        den_r     = (ring_rows_reg >= 9'd2) ? DEN_W'(ring_rows_reg - 9'd1) : DEN_W'(1);
        den_c     = (ring_cols_reg >= 11'd2) ? DEN_W'(ring_cols_reg - 11'd1) : DEN_W'(1);
        lim_w     = (32'(image_width_reg) < MAX_IMAGE_WIDTH) ? WW'(image_width_reg)
                                                             : WW'(MAX_IMAGE_WIDTH);
        lim_h     = (32'(image_height_reg) < MAX_IMAGE_HEIGHT) ? HW'(image_height_reg)
                                                               : HW'(MAX_IMAGE_HEIGHT);
    end

    // Sequencer and datapath registers
    pru_state_t             state_reg, state_next;
    logic [9:0]             col_reg, col_next;
    logic [7:0]             row_reg, row_next;
    logic signed [RQ_W-1:0] radius_reg, radius_next;
    logic [AB-1:0]          k_reg, k_next;
    logic signed [15:0]     sin_reg, sin_next;
    logic signed [PR_W-1:0] prod_x_reg, prod_x_next, prod_y_reg, prod_y_next;
    logic signed [POS_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic                   outside_reg, outside_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [7:0]             m_data_reg, m_data_next;
    logic                   m_flag_reg, m_flag_next;

    logic                   div_start;
    logic [DIV_NUM_W-1:0]   div_num, div_quo;
    logic [DEN_W-1:0]       div_den;
    div_stat_t              div_stat;
    logic [AB-1:0]          rom_addr;
    logic signed [15:0]     rom_q;
    logic                   wr_en, rd_en;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [7:0]             rd_data;

    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic                    out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign wr_addr  = AW'(AW'(in_pixel_row) * AW'(MAX_IMAGE_WIDTH) + AW'(in_pixel_col));
    assign rd_addr  = AW'(AW'(sy_reg[YW-1:0]) * AW'(MAX_IMAGE_WIDTH) + AW'(sx_reg[XW-1:0]));

    // Center plus product, truncated toward zero at the Q23 point
    always_comb begin
        sum_x = (SUM_W'(center_x_reg) <<< Q23_SHIFT) + SUM_W'(prod_x_reg);
        sum_y = (SUM_W'(center_y_reg) <<< Q23_SHIFT) + SUM_W'(prod_y_reg);
        if (sum_x < 0) sum_x = sum_x + SUM_W'((1 << Q23_SHIFT) - 1);
        if (sum_y < 0) sum_y = sum_y + SUM_W'((1 << Q23_SHIFT) - 1);
    end

    // Next state and datapath
    always_comb begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        radius_next   = radius_reg;
        k_next        = k_reg;
        sin_next      = sin_reg;
        prod_x_next   = prod_x_reg;
        prod_y_next   = prod_y_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        outside_next  = outside_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_flag_next   = m_flag_reg;
        div_start     = 1'b0;
        div_num       = DIV_NUM_W'({18'(delta_abs) * 18'(row_reg), 8'b0});
        div_den       = den_r;
        rom_addr      = k_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == OP_WRITE) begin
                        wr_en = (32'(in_pixel_col) < MAX_IMAGE_WIDTH) &&
                                (32'(in_pixel_row) < MAX_IMAGE_HEIGHT);
                    end else begin
                        col_next   = in_ring_col;
                        row_next   = in_ring_row;
                        state_next = S_RDIV;
                    end
                end
            end
            S_RDIV: begin
                div_start  = 1'b1;
                state_next = S_RDIV_WAIT;
            end
            S_RDIV_WAIT: begin
                if (div_stat.done) begin
                    radius_next = $signed(RQ_W'({radius_inner_reg, 8'b0}))
                                + (delta_neg ? -$signed(RQ_W'(div_quo))
                                             : $signed(RQ_W'(div_quo)));
                    state_next  = S_KDIV;
                end
            end
            S_KDIV: begin
                div_start  = 1'b1;
                div_num    = DIV_NUM_W'({col_reg, AB'(0)});
                div_den    = den_c;
                state_next = S_KDIV_WAIT;
            end
            S_KDIV_WAIT: begin
                if (div_stat.done) begin
                    k_next     = div_quo[AB-1:0];
                    state_next = S_ROM_S;
                end
            end
            S_ROM_S: begin
                state_next = S_ROM_C;
            end
            S_ROM_C: begin
                rom_addr   = AB'(k_reg + AB'(QTR));
                sin_next   = rom_q;
                state_next = S_MUL;
            end
            S_MUL: begin
                prod_x_next = radius_reg * rom_q;
                prod_y_next = radius_reg * sin_reg;
                state_next  = S_SUM;
            end
            S_SUM: begin
                sx_next    = sum_x[SUM_W-1:Q23_SHIFT];
                sy_next    = sum_y[SUM_W-1:Q23_SHIFT];
                state_next = S_CHK;
            end
            S_CHK: begin
                outside_next = sx_reg[POS_W-1] || sy_reg[POS_W-1] ||
                               (sx_reg >= $signed(POS_W'(lim_w))) ||
                               (sy_reg >= $signed(POS_W'(lim_h)));
                rd_en        = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = outside_reg ? 8'd0 : rd_data;
                    m_flag_next   = outside_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        col_reg     <= col_next;
        row_reg     <= row_next;
        radius_reg  <= radius_next;
        k_reg       <= k_next;
        sin_reg     <= sin_next;
        prod_x_reg  <= prod_x_next;
        prod_y_reg  <= prod_y_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        outside_reg <= outside_next;
        m_data_reg  <= m_data_next;
        m_flag_reg  <= m_flag_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_flag_reg;

    pru_divider #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .stat    (div_stat)
    );

    pru_sine_rom #(
        .ANGLE_STEPS (ANGLE_STEPS),
        .AB          (AB)
    ) u_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .q    (rom_q)
    );

    pru_image_mem #(
        .AW (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_pixel_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

`ifndef SYNTH
    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_RDIV_WAIT || state_reg == S_KDIV_WAIT))
        else $error("divider done outside a wait state");

    // an outside result carries a zero sample
    a_out_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'd0))
        else $error("outside sample with nonzero value");

    // a finished sample holds while the output register is full
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && m_tvalid_reg && !m_tready) |=> (state_reg == S_OUT))
        else $error("sample left S_OUT with output register full");

    // store writes happen only between samples
    a_wr_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_IDLE && !div_stat.busy))
        else $error("image write during a sample");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of polar_ring_unwrap: directed table, then random ring sampling.
module testbench;
    import pru_pkg::*;

    localparam int  IMG_W       = 512;
    localparam int  IMG_H       = 512;
    localparam int  STEPS       = 4096;
    localparam int  RANDOM_ITEMS = 1830;
    localparam int  SETTLE      = 150;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [7:0] value;
        logic       outside;
    } ring_sample_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t kind;
        int        a;        // pixel_col / ring_col / register index
        int        b;        // pixel_row / ring_row / register data
        int        c;        // pixel_value
        bit        typed;
        int        want_val;
        bit        want_out;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [10:0] cfg_data;

    // Shadow of the block's registers and image store
    int          sh_cx, sh_cy;
    int unsigned sh_rin, sh_rout, sh_rows, sh_cols, sh_w, sh_h;
    logic [7:0]  src_image [IMG_W*IMG_H];
    bit          src_written [IMG_W*IMG_H];

    ring_sample_t pending_samples[$];
    int          errors;
    longint      cycles;
    int          burst_left;

    polar_ring_unwrap u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("polar_ring_unwrap regression: fail");
            $finish;
        end
    end

    // Q1.15 sine of a Q30 angle in [0, 2pi): folded Taylor series to x^15
    function automatic int sine_q15(longint unsigned ang);
        bit                neg;
        longint unsigned   x2, term;
        longint            acc;
        int                q;
        neg = 1'b0;
        if (ang >= PI_Q30) begin
            ang = ang - PI_Q30;
            neg = 1'b1;
        end
        if (ang > HALF_PI_Q30)
            ang = PI_Q30 - ang;
        x2   = (ang * ang) >> 30;
        term = ang;
        acc  = longint'(ang);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        q = int'((acc + 16384) >>> 15);
        if (q > 32767)
            q = 32767;
        return neg ? -q : q;
    endfunction

    // Source position of one ring sample and whether it lies in the image
    function automatic void ring_position(input int unsigned rcol, input int unsigned rrow,
                                          output longint px, output longint py,
                                          output bit in_image);
        longint          den_r, rad_q8, lim_w, lim_h;
        longint unsigned den_c, k, ang, ang_c;
        longint          s, c;
        den_r  = (sh_rows >= 2) ? longint'(sh_rows) - 1 : 1;
        den_c  = (sh_cols >= 2) ? longint'(sh_cols) - 1 : 1;
        rad_q8 = longint'(sh_rin) * 256
               + ((longint'(sh_rout) - longint'(sh_rin)) * 256 * longint'(rrow)) / den_r;
        k      = ((longint'(rcol) * STEPS) / den_c) % STEPS;
        ang    = (k * TWO_PI_Q30) / STEPS;
        ang_c  = ang + HALF_PI_Q30;
        if (ang_c >= TWO_PI_Q30)
            ang_c = ang_c - TWO_PI_Q30;
        s  = sine_q15(ang);
        c  = sine_q15(ang_c);
        px = (longint'(sh_cx) * (64'sd1 << Q23_SHIFT) + rad_q8 * c) / (64'sd1 << Q23_SHIFT);
        py = (longint'(sh_cy) * (64'sd1 << Q23_SHIFT) + rad_q8 * s) / (64'sd1 << Q23_SHIFT);
        lim_w  = (sh_w < IMG_W) ? sh_w : IMG_W;
        lim_h  = (sh_h < IMG_H) ? sh_h : IMG_H;
        in_image = !(px < 0 || px >= lim_w || py < 0 || py >= lim_h);
    endfunction

    // One item on the input channel, with bursts and gaps
    task automatic push_item(input logic op, input int pcol, input int prow, input int pval,
                             input int rcol, input int rrow);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, rrow[7:0], rcol[9:0], pval[7:0], prow[8:0], pcol[8:0]};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    task automatic write_pixel(input int pcol, input int prow, input int pval,
                               input int rcol, input int rrow);
        push_item(OP_WRITE, pcol, prow, pval, rcol, rrow);
        src_image[prow * IMG_W + pcol]   = pval[7:0];
        src_written[prow * IMG_W + pcol] = 1'b1;
    endtask

    // Sample one ring point; first fills the source pixel if it was never written
    task automatic sample_ring(input int rcol, input int rrow, input bit typed,
                               input int want_val, input bit want_out);
        longint       px, py;
        bit           in_image;
        ring_sample_t exp_s;
        ring_position(rcol, rrow, px, py, in_image);
        if (in_image && !src_written[py * IMG_W + px])
            write_pixel(int'(px), int'(py), $urandom_range(0, 255),
                        $urandom_range(0, 1023), $urandom_range(0, 255));
        push_item(OP_SAMPLE, $urandom_range(0, 511), $urandom_range(0, 511),
                  $urandom_range(0, 255), rcol, rrow);
        if (typed) begin
            exp_s.value   = want_val[7:0];
            exp_s.outside = want_out;
        end else if (in_image) begin
            exp_s.value   = src_image[py * IMG_W + px];
            exp_s.outside = 1'b0;
        end else begin
            exp_s.value   = 8'd0;
            exp_s.outside = 1'b1;
        end
        pending_samples.push_back(exp_s);
    endtask

    // Wait until all samples are back and the sequencer has settled
    task automatic drain;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Register write; only called while the block is idle
    task automatic write_reg(input logic [2:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[10:0];
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_CENTER_X:     sh_cx   = int'($signed(value[10:0]));
            REG_CENTER_Y:     sh_cy   = int'($signed(value[10:0]));
            REG_RADIUS_INNER: sh_rin  = value[9:0];
            REG_RADIUS_OUTER: sh_rout = value[9:0];
            REG_RING_ROWS:    sh_rows = value[8:0];
            REG_RING_COLS:    sh_cols = value[10:0];
            REG_IMAGE_WIDTH:  sh_w    = value[9:0];
            REG_IMAGE_HEIGHT: sh_h    = value[9:0];
            default: ;
        endcase
    endtask

    // Receiver: ready pattern switching between free flow, random and heavy stall
    int rx_left;
    int rx_mode;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_left = 0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(5, 300);
            end
            rx_left = rx_left - 1;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                2: m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= ($urandom_range(0, 40) == 0);
            endcase
        end
    end

    // Result check; handshake values are stable between edges
    always @(negedge aclk) begin
        ring_sample_t exp_s;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected item value=%0d outside=%0d", $time,
                         m_tdata, m_tuser);
                errors++;
            end else begin
                exp_s = pending_samples.pop_front();
                if (m_tdata !== exp_s.value) begin
                    $display("%0t: sample_value expected %0d actual %0d", $time,
                             exp_s.value, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== exp_s.outside) begin
                    $display("%0t: outside_image expected %0d actual %0d", $time,
                             exp_s.outside, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // Directed part: reset defaults, short ring, zero and clamped sizes, center extremes
    stim_row_t directed [] = '{
        '{ROW_WRITE,  287, 256, 8'hA5, 0, 0, 0},
        '{ROW_SAMPLE, 0, 0, 0, 1, 8'hA5, 0},
        '{ROW_SAMPLE, 0, 255, 0, 1, 0, 1},
        '{ROW_WRITE,  0, 0, 0, 0, 0, 0},
        '{ROW_WRITE,  511, 511, 255, 0, 0, 0},
        '{ROW_SAMPLE, 1023, 255, 0, 0, 0, 0},
        '{ROW_SAMPLE, 511, 63, 0, 0, 0, 0},
        '{ROW_SAMPLE, 256, 32, 0, 0, 0, 0},
        '{ROW_CFG,    REG_RING_ROWS, 1, 0, 0, 0, 0},
        '{ROW_CFG,    REG_RING_COLS, 1, 0, 0, 0, 0},
        '{ROW_SAMPLE, 5, 3, 0, 0, 0, 0},
        '{ROW_SAMPLE, 1023, 255, 0, 0, 0, 0},
        '{ROW_CFG,    REG_IMAGE_WIDTH, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 0, 0, 0, 1, 0, 1},
        '{ROW_CFG,    REG_IMAGE_WIDTH, 1023, 0, 0, 0, 0},
        '{ROW_CFG,    REG_RING_ROWS, 64, 0, 0, 0, 0},
        '{ROW_CFG,    REG_RING_COLS, 512, 0, 0, 0, 0},
        '{ROW_CFG,    REG_CENTER_X, 1023, 0, 0, 0, 0},
        '{ROW_SAMPLE, 0, 0, 0, 1, 0, 1},
        '{ROW_CFG,    REG_CENTER_X, -1024, 0, 0, 0, 0},
        '{ROW_SAMPLE, 0, 0, 0, 1, 0, 1},
        '{ROW_CFG,    REG_CENTER_X, 256, 0, 0, 0, 0},
        '{ROW_SAMPLE, 2, 0, 0, 0, 0, 0}
    };

    // Random phase settings: random rings, or registers at their low or high ends
    task automatic pick_settings(input int phase);
        case (phase % 4)
            0: begin    // registers at or near their low ends
                write_reg(REG_CENTER_X, -1024);
                write_reg(REG_CENTER_Y, -1024);
                write_reg(REG_RADIUS_INNER, 0);
                write_reg(REG_RADIUS_OUTER, 1);
                write_reg(REG_RING_ROWS, 0);
                write_reg(REG_RING_COLS, 0);
                write_reg(REG_IMAGE_WIDTH, 1);
                write_reg(REG_IMAGE_HEIGHT, 1);
            end
            1: begin    // all registers at their high ends
                write_reg(REG_CENTER_X, 1023);
                write_reg(REG_CENTER_Y, 1023);
                write_reg(REG_RADIUS_INNER, 1023);
                write_reg(REG_RADIUS_OUTER, 1023);
                write_reg(REG_RING_ROWS, 511);
                write_reg(REG_RING_COLS, 2047);
                write_reg(REG_IMAGE_WIDTH, 1023);
                write_reg(REG_IMAGE_HEIGHT, 1023);
            end
            default: begin
                write_reg(REG_CENTER_X, $urandom_range(0, 511));
                write_reg(REG_CENTER_Y, $urandom_range(0, 511));
                write_reg(REG_RADIUS_INNER, $urandom_range(0, 120));
                write_reg(REG_RADIUS_OUTER, $urandom_range(0, 300));
                write_reg(REG_RING_ROWS, $urandom_range(0, 300));
                write_reg(REG_RING_COLS, $urandom_range(0, 1100));
                write_reg(REG_IMAGE_WIDTH, $urandom_range(1, 600));
                write_reg(REG_IMAGE_HEIGHT, $urandom_range(1, 600));
            end
        endcase
    endtask

    initial begin
        int rr;
        errors     = 0;
        cycles     = 0;
        burst_left = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        sh_cx = 256; sh_cy = 256; sh_rin = 32; sh_rout = 128;
        sh_rows = 64; sh_cols = 512; sh_w = 512; sh_h = 512;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            case (directed[i].kind)
                ROW_WRITE:  write_pixel(directed[i].a, directed[i].b, directed[i].c,
                                        $urandom_range(0, 1023), $urandom_range(0, 255));
                ROW_SAMPLE: sample_ring(directed[i].a, directed[i].b, directed[i].typed,
                                        directed[i].want_val, directed[i].want_out);
                default: begin
                    drain();
                    write_reg(directed[i].a[2:0], directed[i].b);
                end
            endcase
        end

        // Random part in phases of roughly 230 items
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 230 == 0) begin
                drain();
                pick_settings(n / 230 + 2);
            end
            if (n % 230 == 115)
                drain();
            if ($urandom_range(0, 9) < 3) begin
                write_pixel($urandom_range(0, 511), $urandom_range(0, 511),
                            $urandom_range(0, 255), $urandom_range(0, 1023),
                            $urandom_range(0, 255));
            end else begin
                rr = ($urandom_range(0, 4) == 0 || sh_rows == 0) ? $urandom_range(0, 255)
                                                                 : $urandom_range(0, sh_rows);
                sample_ring($urandom_range(0, 1023), rr % 256, 1'b0, 0, 1'b0);
            end
        end

        drain();
        if (errors == 0)
            $display("polar_ring_unwrap regression: pass");
        else
            $display("polar_ring_unwrap regression: fail");
        $finish;
    end

endmodule

// ===== polar_ring_unwrap.f =====
hdl/pru_pkg.sv
hdl/pru_divider.sv
hdl/pru_sine_rom.sv
hdl/pru_image_mem.sv
hdl/polar_ring_unwrap.sv
test/testbench.sv
